### sv/pwc_pkg.sv
`default_nettype none
package pwc_pkg;

	// Quotient bits of 2^32 / |denom| with |denom| >= 64
	localparam int QuoW = 27;
	// Magnitude width of the divisor (|denom| < 2^30)
	localparam int DivW = 30;

	localparam logic signed [15:0] KLimit    = 16'sd16384;
	localparam logic signed [32:0] QOne      = 33'sd65536;
	localparam logic signed [32:0] MinDenom  = 33'sd64;
	localparam logic [47:0]        RoundHalf = 48'd32768;

	// Dividend bits above the first quotient bit: 2^32 >> QuoW
	localparam logic [DivW-1:0] RemInit = DivW'(32);

	// Word handed from cell to cell along the divider row
	typedef struct packed {
		logic                valid;
		logic [DivW-1:0]     rem;
		logic [DivW-1:0]     dvs;
		logic [QuoW-1:0]     quo;
		logic                neg;
		logic signed [31:0]  x;
		logic signed [31:0]  y;
	} cell_t;

endpackage
`default_nettype wire

### sv/pwc_if.sv
`default_nettype none
interface pwc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface pwc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] warped_x;
	logic signed [31:0] warped_y;

	modport source (output valid, output warped_x, output warped_y, input ready);
	modport sink (input valid, input warped_x, input warped_y, output ready);
endinterface
`default_nettype wire

### sv/perspective_warp_coordinate.sv
`default_nettype none
// Perspective warp of one signed 32-bit coordinate pair per word: the scale
// 2^32 / (65536 + floor(k*y/65536)) is applied to x and y in Q16.16 with
// rounding, results wrapped to 32 bits. One word is accepted every cycle
// while not stalled; each word passes the depth multiply and divisor setup
// stages, the 27-cell restoring divider row (one quotient bit per cell),
// then the sign, multiply and rounding stages. The whole pipeline holds
// when the output register is full and not taken; coord.ready follows it.
// The strength k is written through wr_en/wr_data, saturated to
// +/-16384, and resets to -16384; write it only while the block is empty.
module perspective_warp_coordinate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [15:0] wr_data,
	pwc_in_if.sink      coord,
	pwc_out_if.source   warped
);
	import pwc_pkg::*;

	logic               adv;
	logic               out_valid;
	logic signed [15:0] k_q;
	logic signed [15:0] wr_k;
	cell_t              chain [0:QuoW];

	// Advance everything when the output register is free or being taken
	assign adv         = !out_valid || warped.ready;
	assign coord.ready = adv;

	// Hold the saturated warp strength
	assign wr_k = $signed(wr_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= -KLimit;
		end else if (wr_en) begin
			if (wr_k > KLimit) begin
				k_q <= KLimit;
			end else if (wr_k < -KLimit) begin
				k_q <= -KLimit;
			end else begin
				k_q <= wr_k;
			end
		end
	end

	pwc_denom u_denom (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (coord.valid),
		.x_coord  (coord.x_coord),
		.y_coord  (coord.y_coord),
		.k        (k_q),
		.cell_o   (chain[0])
	);

	// Divider row, one quotient bit per cell
	for (genvar i = 0; i < QuoW; i++) begin : g_cell
		pwc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.cell_i (chain[i]),
			.cell_o (chain[i+1])
		);
	end

	pwc_apply u_apply (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cell_i    (chain[QuoW]),
		.out_valid (out_valid),
		.warped_x  (warped.warped_x),
		.warped_y  (warped.warped_y)
	);

	assign warped.valid = out_valid;

	// Strength stays within its limits
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q <= KLimit) && (k_q >= -KLimit))
		else $error("warp strength out of range");

	// Divisor entering the row is never below the clamp
	a_dvs_min: assert property (@(posedge clk) disable iff (!arst_n)
		chain[0].valid |-> (chain[0].dvs >= DivW'(64)))
		else $error("divisor below clamp");

	// Final remainder is less than the divisor
	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		chain[QuoW].valid |-> (chain[QuoW].rem < chain[QuoW].dvs))
		else $error("divider remainder not reduced");

	// A stall freezes the tail of the row
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(chain[QuoW]))
		else $error("divider row moved during stall");

endmodule
`default_nettype wire

### sv/pwc_denom.sv
`default_nettype none
module pwc_denom (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic signed [15:0] k,
	output pwc_pkg::cell_t     cell_o
);
	import pwc_pkg::*;

	logic               v_s1;
	logic signed [31:0] x_s1;
	logic signed [31:0] y_s1;
	logic signed [47:0] prod_s1;
	logic signed [31:0] ky;
	logic signed [32:0] denom;
	logic signed [32:0] denom_cl;
	logic               neg;
	logic [32:0]        mag;
	cell_t              cell_q;

	// Stage 1: depth product k*y
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= x_coord;
			y_s1    <= y_coord;
			prod_s1 <= k * y_coord;
		end
	end

	// Floor shift, add one, keep the divisor away from zero
	always_comb begin
		ky    = $signed(prod_s1[47:16]);
		denom = QOne + 33'(ky);
		neg   = denom[32];
		if (denom > -MinDenom && denom < MinDenom) begin
			denom_cl = neg ? -MinDenom : MinDenom;
		end else begin
			denom_cl = denom;
		end
		mag = neg ? 33'(-denom_cl) : 33'(denom_cl);
	end

	// Stage 2: load the head of the divider row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (adv) begin
			cell_q.valid <= v_s1;
			cell_q.rem   <= RemInit;
			cell_q.dvs   <= mag[DivW-1:0];
			cell_q.quo   <= '0;
			cell_q.neg   <= neg;
			cell_q.x     <= x_s1;
			cell_q.y     <= y_s1;
		end
	end

	assign cell_o = cell_q;

endmodule
`default_nettype wire

### sv/pwc_div_cell.sv
`default_nettype none
module pwc_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  pwc_pkg::cell_t cell_i,
	output pwc_pkg::cell_t cell_o
);
	import pwc_pkg::*;

	logic [DivW:0] trial;
	logic          ge;
	cell_t         cell_q;

	// One restoring step: shift, try subtract, emit one quotient bit
	assign trial = {cell_i.rem, 1'b0};
	assign ge    = trial >= {1'b0, cell_i.dvs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (adv) begin
			cell_q.valid <= cell_i.valid;
			cell_q.rem   <= ge ? DivW'(trial - {1'b0, cell_i.dvs}) : trial[DivW-1:0];
			cell_q.dvs   <= cell_i.dvs;
			cell_q.quo   <= {cell_i.quo[QuoW-2:0], ge};
			cell_q.neg   <= cell_i.neg;
			cell_q.x     <= cell_i.x;
			cell_q.y     <= cell_i.y;
		end
	end

	assign cell_o = cell_q;

endmodule
`default_nettype wire

### sv/pwc_apply.sv
`default_nettype none
module pwc_apply (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  pwc_pkg::cell_t     cell_i,
	output logic               out_valid,
	output logic signed [31:0] warped_x,
	output logic signed [31:0] warped_y
);
	import pwc_pkg::*;

	logic                   v_s1;
	logic                   v_s2;
	logic                   valid_q;
	logic signed [QuoW:0]   qs;
	logic signed [QuoW:0]   scale_s1;
	logic signed [31:0]     x_s1;
	logic signed [31:0]     y_s1;
	logic signed [59:0]     px;
	logic signed [59:0]     py;
	logic [47:0]            px_s2;
	logic [47:0]            py_s2;
	logic [47:0]            sum_x;
	logic [47:0]            sum_y;
	logic signed [31:0]     warped_x_q;
	logic signed [31:0]     warped_y_q;

	assign qs  = $signed({1'b0, cell_i.quo});
	assign px  = x_s1 * scale_s1;
	assign py  = y_s1 * scale_s1;
	assign sum_x = px_s2 + RoundHalf;
	assign sum_y = py_s2 + RoundHalf;

	// Advance valid bits through sign, multiply and round stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= cell_i.valid;
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	// Apply sign to quotient, multiply, then round and floor-shift
	always_ff @(posedge clk) begin
		if (adv) begin
			scale_s1   <= cell_i.neg ? -qs : qs;
			x_s1       <= cell_i.x;
			y_s1       <= cell_i.y;
			px_s2      <= px[47:0];
			py_s2      <= py[47:0];
			warped_x_q <= $signed(sum_x[47:16]);
			warped_y_q <= $signed(sum_y[47:16]);
		end
	end

	assign out_valid = valid_q;
	assign warped_x  = warped_x_q;
	assign warped_y  = warped_y_q;

endmodule
`default_nettype wire
